// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the shared-buffer stack block.
// Define NO_ASSERTIONS to compile the assertions out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_CLK(lbl, ck, rstn, prop, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) prop) else $error(msg);

`define ASSERT_NEVER(lbl, ck, rstn, expr, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) !(expr)) else $error(msg);

`else

`define ASSERT_CLK(lbl, ck, rstn, prop, msg)

`define ASSERT_NEVER(lbl, ck, rstn, expr, msg)

`endif

`endif

// ----- rtl/ksb_pkg.sv -----
// Package for the shared-buffer stack block: sizes, pointer type, codes and
// the command bundle between controller and datapath. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ksb_pkg;

    localparam int NUM_STACKS = 4;
    localparam int NUM_SLOTS  = 16;
    localparam int DATA_WIDTH = 32;

    localparam int WORD_W   = 32;
    localparam int SID_W    = 2;
    localparam int STATUS_W = 2;
    localparam int PTR_W    = $clog2(NUM_SLOTS + 1);
    localparam int ADDR_W   = $clog2(NUM_SLOTS);
    localparam int STK_W    = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;

    typedef logic [PTR_W-1:0] ptr_t;

    // The null pointer is one past the last slot.
    localparam ptr_t NULL_PTR = ptr_t'(NUM_SLOTS);

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } status_t;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } op_t;

    typedef struct packed {
        logic load;    // latch the incoming word and start the memory reads
        logic commit;  // update pointers and memories, load the result register
    } ksb_cmd_t;

    function automatic logic is_null(input ptr_t p);
        return (p >= NULL_PTR);
    endfunction

    function automatic ptr_t norm_ptr(input ptr_t p);
        return is_null(p) ? NULL_PTR : p;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/ksb_ctrl.sv -----
// Controller of the shared-buffer stack block: two-state sequencer and the
// output valid flag. Depends on ksb_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ksb_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output ksb_pkg::ksb_cmd_t      cmd
);
    import ksb_pkg::*;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign s_tready   = (state_reg == S_IDLE);
    assign out_free   = !out_valid_reg || m_tready;
    assign cmd.load   = s_tvalid && s_tready;
    assign cmd.commit = (state_reg == S_EXEC) && out_free;
    assign m_tvalid   = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.load)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // The result waits here until the output register has room.
                if (cmd.commit)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `ASSERT_CLK(a_load_then_busy, clk, rst_n, cmd.load |=> !s_tready, "ready after accepting a word")
    `ASSERT_CLK(a_commit_gives_word, clk, rst_n, cmd.commit |=> m_tvalid, "commit lost its result")
    `ASSERT_NEVER(a_load_commit_excl, clk, rst_n, cmd.load && cmd.commit, "load and commit together")

endmodule

`default_nettype wire

// ----- rtl/ksb_datapath.sv -----
// Datapath of the shared-buffer stack block: free-list head, stack tops,
// link and value memories and the result register. Depends on ksb_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ksb_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire ksb_pkg::ksb_cmd_t             cmd,
    input  wire logic                          in_mode,
    input  wire logic [ksb_pkg::SID_W-1:0]     in_sid,
    input  wire logic signed [ksb_pkg::WORD_W-1:0] in_value,
    output logic signed [ksb_pkg::WORD_W-1:0]  pop_value,
    output logic [ksb_pkg::STATUS_W-1:0]       status
);
    import ksb_pkg::*;

    // Pointer state.
    ptr_t free_head_reg;
    ptr_t free_head_next;
    ptr_t tops_reg  [NUM_STACKS];
    ptr_t tops_next [NUM_STACKS];
    // Slots at or above the fill mark were never taken from the initial
    // chain, so their link is still slot+1 and needs no memory read.
    ptr_t fill_reg;
    ptr_t fill_next;

    // Operation latched at accept.
    op_t                          mode_reg;
    logic [STK_W-1:0]             idx_reg;
    logic                         ok_reg;
    ptr_t                         slot_reg;
    ptr_t                         top_reg;
    logic signed [DATA_WIDTH-1:0] value_reg;

    // Slot store.
    ptr_t                   link_mem [NUM_SLOTS];
    logic [DATA_WIDTH-1:0]  val_mem  [NUM_SLOTS];
    ptr_t                   link_q;
    logic signed [DATA_WIDTH-1:0] val_q;

    logic signed [WORD_W-1:0] pop_value_reg;
    status_t                  status_reg;

    // Accept-side selection.
    logic             sid_ok;
    logic [STK_W-1:0] idx_in;
    ptr_t             top_sel;
    ptr_t             slot_sel;

    // Execute-side values.
    logic fresh;
    ptr_t nxt;
    logic push_ok;
    logic pop_ok;

    assign sid_ok   = (32'(in_sid) < 32'(NUM_STACKS));
    assign idx_in   = STK_W'(in_sid);
    assign top_sel  = sid_ok ? tops_reg[idx_in] : NULL_PTR;
    assign slot_sel = (op_t'(in_mode) == OP_POP) ? top_sel : free_head_reg;

    assign fresh   = (slot_reg >= fill_reg);
    assign nxt     = norm_ptr(fresh ? (slot_reg + ptr_t'(1)) : link_q);
    assign push_ok = ok_reg && (mode_reg == OP_PUSH);
    assign pop_ok  = ok_reg && (mode_reg == OP_POP);

    always_comb
    begin
        free_head_next = free_head_reg;
        tops_next      = tops_reg;
        fill_next      = fill_reg;
        if (cmd.commit)
        begin
            if (push_ok)
            begin
                free_head_next    = nxt;
                tops_next[idx_reg] = slot_reg;
                if (fresh)
                begin
                    fill_next = fill_reg + ptr_t'(1);
                end
            end
            else if (pop_ok)
            begin
                tops_next[idx_reg] = nxt;
                free_head_next     = slot_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_head_reg <= '0;
            fill_reg      <= '0;
            for (int i = 0; i < NUM_STACKS; i++)
            begin
                tops_reg[i] <= NULL_PTR;
            end
        end
        else
        begin
            free_head_reg <= free_head_next;
            fill_reg      <= fill_next;
            tops_reg      <= tops_next;
        end
    end

    // Latched operation and result register: payload, no reset.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg  <= op_t'(in_mode);
            idx_reg   <= idx_in;
            ok_reg    <= sid_ok && !is_null(slot_sel);
            slot_reg  <= slot_sel;
            top_reg   <= top_sel;
            value_reg <= DATA_WIDTH'(in_value);
        end
        if (cmd.commit)
        begin
            pop_value_reg <= pop_ok ? WORD_W'(val_q) : '1;
            if (ok_reg)
            begin
                status_reg <= ST_OK;
            end
            else if (mode_reg == OP_PUSH)
            begin
                status_reg <= ST_OVERFLOW;
            end
            else
            begin
                status_reg <= ST_UNDERFLOW;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            link_q <= link_mem[ADDR_W'(slot_sel)];
            val_q  <= val_mem[ADDR_W'(slot_sel)];
        end
        if (cmd.commit && push_ok)
        begin
            link_mem[ADDR_W'(slot_reg)] <= top_reg;
            val_mem[ADDR_W'(slot_reg)]  <= value_reg;
        end
        else if (cmd.commit && pop_ok)
        begin
            link_mem[ADDR_W'(slot_reg)] <= free_head_reg;
        end
    end

    assign pop_value = pop_value_reg;
    assign status    = status_reg;

    `ASSERT_NEVER(a_head_range, clk, rst_n, free_head_reg > NULL_PTR, "free head beyond null")
    `ASSERT_NEVER(a_fill_range, clk, rst_n, fill_reg > NULL_PTR, "fill mark beyond slot count")
    `ASSERT_CLK(a_pop_frees_slot, clk, rst_n, cmd.commit && pop_ok |=> free_head_reg == $past(slot_reg), "popped slot not at free head")

endmodule

`default_nettype wire

// ----- rtl/k_stacks_shared_buffer.sv -----
// Top level of the shared-buffer stack block: controller plus datapath.
// Depends on ksb_pkg, ksb_ctrl and ksb_datapath.
`timescale 1ns / 1ps
`default_nettype none

// Several LIFO stacks share one store of slots; free slots sit on a linked
// free list and each stack is a linked chain from its top pointer. Each
// input word is a push or a pop for one stack and yields exactly one output
// word: the popped value (all ones for a push or on underflow) and a status
// of ok, overflow or underflow. On acceptance the link and value memories
// are read into registers; the commit then rewrites the pointers and the
// memories and loads the result register once the output register has room.
// No new word is accepted until the previous one is committed; the next one
// is taken while the previous result still waits in the output register.
// No clearing pass is needed after reset.
module k_stacks_shared_buffer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] push_value
    input  wire logic [2:0]  s_tuser,   // [0] mode, [2:1] stack_id
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [31:0] pop_value
    output logic [1:0]       m_tuser    // [1:0] status
);
    import ksb_pkg::*;

    ksb_cmd_t                 cmd;
    logic signed [WORD_W-1:0] pop_value;
    logic [STATUS_W-1:0]      status;

    ksb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    ksb_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_mode   (s_tuser[0]),
        .in_sid    (s_tuser[2:1]),
        .in_value  ($signed(s_tdata)),
        .pop_value (pop_value),
        .status    (status)
    );

    assign m_tdata = pop_value;
    assign m_tuser = status;

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
// Testbench for k_stacks_shared_buffer: random and directed push/pop words,
// with a free-list model of the shared slot store predicting each result.
// Depends on ksb_pkg and the k_stacks_shared_buffer RTL.
`timescale 1ns / 1ps

import ksb_pkg::*;

typedef struct packed {
    logic [31:0] value;
    status_t     status;
} stack_result_t;

class stack_checker;
    ptr_t                  free_head;
    ptr_t                  tops [NUM_STACKS];
    ptr_t                  links [NUM_SLOTS];
    logic [DATA_WIDTH-1:0] cells [NUM_SLOTS];
    stack_result_t         pending_results [$];
    int                    mismatches;

    function new();
        free_head  = '0;
        mismatches = 0;
        foreach (tops[i])
            tops[i] = NULL_PTR;
        foreach (links[i])
        begin
            links[i] = (i + 1 < NUM_SLOTS) ? ptr_t'(i + 1) : NULL_PTR;
            cells[i] = '0;
        end
    endfunction

    function void flag(string what, logic [31:0] want, logic [31:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, want, got);
    endfunction

    // Applies one accepted word to the shared store and queues its result.
    function void note_word(op_t op, logic [SID_W-1:0] sid, logic [31:0] value);
        stack_result_t res;
        ptr_t          slot;
        res.value  = '1;
        res.status = ST_OK;
        if (op == OP_PUSH)
        begin
            slot = free_head;
            if (sid >= NUM_STACKS || slot >= NUM_SLOTS)
                res.status = ST_OVERFLOW;
            else
            begin
                free_head   = (links[slot] < NUM_SLOTS) ? links[slot] : NULL_PTR;
                links[slot] = (tops[sid] < NUM_SLOTS) ? tops[sid] : NULL_PTR;
                tops[sid]   = slot;
                cells[slot] = DATA_WIDTH'(signed'(value));
            end
        end
        else
        begin
            if (sid >= NUM_STACKS || tops[sid] >= NUM_SLOTS)
                res.status = ST_UNDERFLOW;
            else
            begin
                slot        = tops[sid];
                tops[sid]   = (links[slot] < NUM_SLOTS) ? links[slot] : NULL_PTR;
                links[slot] = (free_head < NUM_SLOTS) ? free_head : NULL_PTR;
                free_head   = slot;
                res.value   = 32'(signed'(cells[slot]));
            end
        end
        pending_results.push_back(res);
    endfunction

    function void check_word(logic [31:0] value, logic [STATUS_W-1:0] status);
        stack_result_t want;
        if (pending_results.size() == 0)
        begin
            flag("unexpected result word", '0, value);
            return;
        end
        want = pending_results.pop_front();
        if (value !== want.value)
            flag("pop_value", want.value, value);
        if (status !== want.status)
            flag("status", 32'(want.status), 32'(status));
    endfunction
endclass

module tb_top;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 645;
    localparam int DRAIN_LIMIT  = 5000;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [31:0]       s_tdata;    // [31:0] push_value
    logic [2:0]        s_tuser;    // [0] mode, [2:1] stack_id
    logic              m_tvalid;
    logic              m_tready;
    logic [31:0]       m_tdata;    // [31:0] pop_value
    logic [1:0]        m_tuser;    // [1:0] status

    stack_checker checker_h = new();
    int           send_idle;
    int           recv_idle;
    int           stall_asks;
    int           stall_done;

    k_stacks_shared_buffer i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Both handshakes are sampled at the edge, before any update lands.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                checker_h.note_word(op_t'(s_tuser[0]), s_tuser[2:1], s_tdata);
            if (m_tvalid && m_tready)
                checker_h.check_word(m_tdata, m_tuser);
        end
    end

    // Output side: random back-pressure, plus long holds on request.
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (stall_done != stall_asks)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                stall_done++;
            end
            m_tready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    task automatic send_word(input op_t op, input logic [SID_W-1:0] sid,
                             input logic [31:0] value);
        while ($urandom_range(0, 99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {sid, op};
        s_tdata  <= value;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return 32'($urandom_range(0, 15));
            default: return $urandom;
        endcase
    endfunction

    // The push share swings between filling and draining, so the store
    // regularly runs full and stacks regularly run dry.
    task automatic random_words(input int count);
        int               push_pct;
        int               focus;
        logic [SID_W-1:0] sid;
        op_t              op;
        push_pct = 50;
        focus    = 0;
        for (int n = 0; n < count; n++)
        begin
            if (n % 40 == 0)
            begin
                case ($urandom_range(0, 4))
                    0: push_pct = 85;
                    1: push_pct = 15;
                    2: push_pct = 70;
                    3: push_pct = 30;
                    default: push_pct = 50;
                endcase
                focus = $urandom_range(0, NUM_STACKS - 1);
            end
            op  = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
            sid = ($urandom_range(0, 3) == 0) ? SID_W'(focus) : SID_W'($urandom);
            send_word(op, sid, pick_value());
        end
    endtask

    initial
    begin
        int drained;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        rst_n      = 1'b0;
        stall_asks = 0;
        stall_done = 0;
        send_idle  = 29;
        recv_idle  = 72;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Every stack starts empty.
        for (int s = 0; s < NUM_STACKS; s++)
            send_word(OP_POP, SID_W'(s), 32'h5A5A_A5A5);
        send_word(OP_PUSH, 2'd0, 32'h7FFF_FFFF);
        send_word(OP_PUSH, 2'd1, 32'h8000_0000);
        send_word(OP_PUSH, 2'd2, 32'h0000_0000);
        send_word(OP_PUSH, 2'd3, 32'hFFFF_FFFF);
        send_word(OP_PUSH, 2'd0, 32'h0000_0001);
        send_word(OP_POP,  2'd0, 32'hFFFF_FFFF);
        send_word(OP_POP,  2'd0, 32'h0000_0000);
        send_word(OP_POP,  2'd0, 32'h1234_5678);
        send_word(OP_POP,  2'd1, 32'h0000_0000);
        send_word(OP_POP,  2'd2, 32'hFFFF_FFFF);
        send_word(OP_POP,  2'd3, 32'h0000_0000);

        random_words(PHASE_ITEMS);
        send_idle = 72;
        recv_idle <= 29;
        random_words(PHASE_ITEMS);
        send_idle = 0;
        recv_idle <= 0;
        // Hold the output off while words keep coming so the input stalls.
        stall_asks++;
        random_words(PHASE_ITEMS);
        s_tvalid <= 1'b0;

        drained = 0;
        while (checker_h.pending_results.size() != 0 && drained < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drained++;
        end
        repeat (20) @(posedge clk);
        if (checker_h.mismatches == 0 && checker_h.pending_results.size() == 0)
            $display("k_stacks_shared_buffer test passed");
        else
            $display("k_stacks_shared_buffer test failed");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("k_stacks_shared_buffer test failed");
        $finish;
    end
endmodule

// ----- sim.f -----
+incdir+rtl
rtl/ksb_pkg.sv
rtl/ksb_ctrl.sv
rtl/ksb_datapath.sv
rtl/k_stacks_shared_buffer.sv
bench/tb_top.sv
